// ----- hdl/frp_pkg.sv -----
// Shared types, codes and character helpers for the FASTA record parser.
// No dependencies; used by every module of the block by scoped names.
package frp_pkg;

   localparam int LENGTH_WIDTH_DEFAULT = 32;
   localparam int RECORD_LENGTH_WIDTH  = 32;
   localparam int QUEUE_DEPTH          = 4;
   localparam int QUEUE_PTR_WIDTH      = 2;
   localparam int QUEUE_CNT_WIDTH      = 3;
   localparam int RSP_TDATA_WIDTH      = 48;

   localparam logic [7:0] HEADER_MARK = 8'h3E;
   localparam logic [7:0] LINE_FEED   = 8'h0A;

   typedef enum logic [1:0] {
      MODE_SKIP = 2'd0,
      MODE_NAME = 2'd1,
      MODE_REST = 2'd2,
      MODE_SEQ  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_NAME_CHAR = 3'd0,
      KIND_NAME_DONE = 3'd1,
      KIND_UNNAMED   = 3'd2,
      KIND_LETTER    = 3'd3,
      KIND_END       = 3'd4
   } kind_type;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_EOS  = 1'b1
   } op_type;

   typedef struct packed {
      kind_type                         kind;
      logic [7:0]                       char_out;
      logic [RECORD_LENGTH_WIDTH-1:0]   record_length;
      logic                             last_of_run;
   } result_type;

   // Results produced by one accepted word: zero, one or two.
   typedef struct packed {
      logic [1:0]  count;
      result_type  first;
      result_type  second;
   } push_type;

   function automatic logic is_ws(input logic [7:0] b);
      is_ws = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      is_letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
   endfunction

endpackage

// ----- hdl/fasta_record_parser_top.sv -----
// Results: a result is written into the result queue and appears on rsp from
// its head. Throughput: one input word per cycle while results are taken; a word
// that gives two results hands them out one at a time through the
// single-result output port after a four-entry result queue.
// Reset: synchronous, active high; clears parse state and empties the queue.
// Depends on frp_pkg, frp_parse_core and frp_result_queue.
module fasta_record_parser_top #(
   parameter int LENGTH_WIDTH = frp_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic [0:0]  req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [frp_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
                                    // [2:0] kind, [10:3] char_out,
                                    // [42:11] record_length, [47:43] zero
   output logic        rsp_tlast    // last_of_run
);

   localparam int PAD_WIDTH = frp_pkg::RSP_TDATA_WIDTH - 3 - 8
                              - frp_pkg::RECORD_LENGTH_WIDTH;

   logic                req_accept;
   logic                rsp_pop;
   frp_pkg::push_type   push;
   frp_pkg::result_type head;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   frp_parse_core #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .operation (req_tuser[0]),
      .text_byte (req_tdata),
      .push      (push)
   );

   frp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_pop),
      .has_room  (req_tready),
      .not_empty (rsp_tvalid),
      .head      (head)
   );

   assign rsp_tdata = {{PAD_WIDTH{1'b0}}, head.record_length, head.char_out, head.kind};
   assign rsp_tlast = head.last_of_run;

endmodule

// ----- hdl/frp_parse_core.sv -----
// Parse state registers and the per-byte mode update of the FASTA parser.
// Depends on frp_pkg; emits up to two results per accepted word.
module frp_parse_core #(
   parameter int LENGTH_WIDTH = frp_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               operation,
   input  logic [7:0]         text_byte,
   output frp_pkg::push_type  push
);

   frp_pkg::mode_type          mode_ff, mode_in;
   logic                       line_start_ff, line_start_in;
   logic [LENGTH_WIDTH-1:0]    count_ff, count_in;
   logic [LENGTH_WIDTH-1:0]    count_inc;
   logic [frp_pkg::RECORD_LENGTH_WIDTH-1:0] sat_len;

   // Clamp the count to the 32-bit result field.
   generate
      if (LENGTH_WIDTH > frp_pkg::RECORD_LENGTH_WIDTH) begin : g_wide
         assign sat_len = (|count_ff[LENGTH_WIDTH-1:frp_pkg::RECORD_LENGTH_WIDTH]) ?
                          '1 : count_ff[frp_pkg::RECORD_LENGTH_WIDTH-1:0];
      end else if (LENGTH_WIDTH == frp_pkg::RECORD_LENGTH_WIDTH) begin : g_equal
         assign sat_len = count_ff;
      end else begin : g_narrow
         assign sat_len = {{(frp_pkg::RECORD_LENGTH_WIDTH-LENGTH_WIDTH){1'b0}}, count_ff};
      end
   endgenerate

   assign count_inc = (&count_ff) ? count_ff : count_ff + 1'b1;

   always_comb begin
      frp_pkg::result_type r0;
      frp_pkg::result_type r1;
      logic [1:0]          n;
      r0            = '0;
      r1            = '0;
      n             = 2'd0;
      mode_in       = mode_ff;
      line_start_in = line_start_ff;
      count_in      = count_ff;

      if (accept) begin
         if (operation == frp_pkg::OP_EOS) begin
            if (mode_ff == frp_pkg::MODE_NAME) begin
               r0.kind          = frp_pkg::KIND_NAME_DONE;
               r1.kind          = frp_pkg::KIND_END;
               r1.record_length = sat_len;
               n                = 2'd2;
            end else if (mode_ff != frp_pkg::MODE_SKIP) begin
               r0.kind          = frp_pkg::KIND_END;
               r0.record_length = sat_len;
               n                = 2'd1;
            end
            mode_in       = frp_pkg::MODE_SKIP;
            line_start_in = 1'b1;
            count_in      = '0;
         end else begin
            unique case (mode_ff)
               frp_pkg::MODE_SKIP: begin
                  if (!frp_pkg::is_ws(text_byte)) begin
                     count_in = '0;
                     if (text_byte == frp_pkg::HEADER_MARK) begin
                        mode_in = frp_pkg::MODE_NAME;
                     end else begin
                        r0.kind       = frp_pkg::KIND_UNNAMED;
                        n             = 2'd1;
                        mode_in       = frp_pkg::MODE_SEQ;
                        line_start_in = (text_byte == frp_pkg::LINE_FEED);
                        if (frp_pkg::is_letter(text_byte)) begin
                           count_in    = {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
                           r1.kind     = frp_pkg::KIND_LETTER;
                           r1.char_out = text_byte;
                           n           = 2'd2;
                        end
                     end
                  end
               end
               frp_pkg::MODE_NAME: begin
                  n = 2'd1;
                  if (frp_pkg::is_ws(text_byte)) begin
                     r0.kind = frp_pkg::KIND_NAME_DONE;
                     if (text_byte == frp_pkg::LINE_FEED) begin
                        mode_in       = frp_pkg::MODE_SEQ;
                        line_start_in = 1'b1;
                     end else begin
                        mode_in = frp_pkg::MODE_REST;
                     end
                  end else begin
                     r0.kind     = frp_pkg::KIND_NAME_CHAR;
                     r0.char_out = text_byte;
                  end
               end
               frp_pkg::MODE_REST: begin
                  if (text_byte == frp_pkg::LINE_FEED) begin
                     mode_in       = frp_pkg::MODE_SEQ;
                     line_start_in = 1'b1;
                  end
               end
               frp_pkg::MODE_SEQ: begin
                  if (line_start_ff && (text_byte == frp_pkg::HEADER_MARK)) begin
                     r0.kind          = frp_pkg::KIND_END;
                     r0.record_length = sat_len;
                     n                = 2'd1;
                     count_in         = '0;
                     mode_in          = frp_pkg::MODE_NAME;
                     line_start_in    = 1'b0;
                  end else if (text_byte == frp_pkg::LINE_FEED) begin
                     line_start_in = 1'b1;
                  end else begin
                     line_start_in = 1'b0;
                     if (frp_pkg::is_letter(text_byte)) begin
                        count_in    = count_inc;
                        r0.kind     = frp_pkg::KIND_LETTER;
                        r0.char_out = text_byte;
                        n           = 2'd1;
                     end
                  end
               end
               default: begin
                  mode_in = frp_pkg::MODE_SKIP;
               end
            endcase
         end
      end

      // Mark the final result of this word.
      if (n == 2'd2) begin
         r1.last_of_run = 1'b1;
      end else begin
         r0.last_of_run = 1'b1;
      end

      push.count  = n;
      push.first  = r0;
      push.second = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= frp_pkg::MODE_SKIP;
         line_start_ff <= 1'b1;
         count_ff      <= '0;
      end else begin
         mode_ff       <= mode_in;
         line_start_ff <= line_start_in;
         count_ff      <= count_in;
      end
   end

endmodule

// ----- hdl/frp_result_queue.sv -----
// Four-entry result queue: takes up to two results per cycle, hands out one.
// Depends on frp_pkg for the result and push structs.
module frp_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  frp_pkg::push_type   push,
   input  logic                pop,
   output logic                has_room,
   output logic                not_empty,
   output frp_pkg::result_type head
);

   frp_pkg::result_type entries_ff [frp_pkg::QUEUE_DEPTH];
   logic [frp_pkg::QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [frp_pkg::QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [frp_pkg::QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic [frp_pkg::QUEUE_PTR_WIDTH-1:0] wr_next;

   assign wr_next   = wr_ptr_ff + 1'b1;
   // Room for a worst-case pair of results.
   assign has_room  = (count_ff <= frp_pkg::QUEUE_CNT_WIDTH'(frp_pkg::QUEUE_DEPTH - 2));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = rd_ptr_ff + {{(frp_pkg::QUEUE_PTR_WIDTH-1){1'b0}}, pop};
      count_in  = count_ff + {1'b0, push.count}
                  - {{(frp_pkg::QUEUE_CNT_WIDTH-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/frp_checker.sv -----
// Port-level checks for the FASTA record parser, bound to the top level.
// Depends on frp_pkg for the output width only.
module frp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [frp_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input logic        rsp_tlast
);

   // Queue is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // No word in and nothing queued: nothing may appear.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && !(req_tvalid && req_tready)) |=> !rsp_tvalid)
      else $error("result appeared without an input word");

   // Input stalls only while results are waiting.
   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with empty result queue");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
      (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind fasta_record_parser_top frp_checker u_frp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- bench/fasta_record_parser_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for fasta_record_parser_top: drives FASTA text words and
// compares every rsp word against a behavioral parse predictor.
// Depends on frp_pkg and the fasta_record_parser_top RTL.
module fasta_record_parser_top_tb;

   localparam int          LEN_W         = frp_pkg::LENGTH_WIDTH_DEFAULT;
   localparam logic [63:0] COUNT_MAX     = (LEN_W >= 64) ? {64{1'b1}} :
                                           ((64'd1 << LEN_W) - 64'd1);
   localparam int          RANDOM_ITEMS  = 1700;
   localparam int          REPORT_LIMIT  = 10;
   localparam int          END_WAIT_MAX  = 50000;

   // receiver stall styles
   localparam int STALL_NONE     = 0;
   localparam int STALL_COIN     = 1;
   localparam int STALL_PERIODIC = 2;
   localparam int STALL_LONG     = 3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] text_byte
   logic [0:0]  req_tuser  = 1'b0;    // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [frp_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;
                                      // [2:0] kind, [10:3] char_out,
                                      // [42:11] record_length, [47:43] zero
   logic        rsp_tlast;            // last_of_run

   frp_pkg::result_type expected_results [$];
   frp_pkg::mode_type   parse_state = frp_pkg::MODE_SKIP;
   logic                line_start  = 1'b1;
   logic [63:0]         letters     = 64'd0;

   int items_sent  = 0;
   int mismatches  = 0;
   int burst_left  = 0;
   int stall_left  = 0;
   int stall_style = STALL_NONE;

   fasta_record_parser_top #(.LENGTH_WIDTH(LEN_W)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic blank_byte(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic alpha_byte(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic frp_pkg::result_type make_result(input frp_pkg::kind_type k,
                                                       input logic [7:0] c,
                                                       input logic [63:0] len);
      frp_pkg::result_type r;
      r.kind          = k;
      r.char_out      = c;
      r.record_length = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
      r.last_of_run   = 1'b0;
      return r;
   endfunction

   task automatic predict_parse(input frp_pkg::op_type op, input logic [7:0] b);
      frp_pkg::result_type res [0:1];
      int                  n;
      n = 0;
      if (op == frp_pkg::OP_EOS) begin
         if (parse_state == frp_pkg::MODE_NAME) begin
            res[n] = make_result(frp_pkg::KIND_NAME_DONE, 8'h00, 64'd0);
            n++;
         end
         if (parse_state != frp_pkg::MODE_SKIP) begin
            res[n] = make_result(frp_pkg::KIND_END, 8'h00, letters);
            n++;
         end
         parse_state = frp_pkg::MODE_SKIP;
         line_start  = 1'b1;
         letters     = 64'd0;
      end else begin
         case (parse_state)
            frp_pkg::MODE_SKIP: begin
               if (!blank_byte(b)) begin
                  letters = 64'd0;
                  if (b == frp_pkg::HEADER_MARK) begin
                     parse_state = frp_pkg::MODE_NAME;
                  end else begin
                     res[n] = make_result(frp_pkg::KIND_UNNAMED, 8'h00, 64'd0);
                     n++;
                     parse_state = frp_pkg::MODE_SEQ;
                     line_start  = (b == frp_pkg::LINE_FEED);
                     if (alpha_byte(b)) begin
                        if (letters < COUNT_MAX) letters++;
                        res[n] = make_result(frp_pkg::KIND_LETTER, b, 64'd0);
                        n++;
                     end
                  end
               end
            end
            frp_pkg::MODE_NAME: begin
               if (blank_byte(b)) begin
                  res[n] = make_result(frp_pkg::KIND_NAME_DONE, 8'h00, 64'd0);
                  n++;
                  if (b == frp_pkg::LINE_FEED) begin
                     parse_state = frp_pkg::MODE_SEQ;
                     line_start  = 1'b1;
                  end else begin
                     parse_state = frp_pkg::MODE_REST;
                  end
               end else begin
                  res[n] = make_result(frp_pkg::KIND_NAME_CHAR, b, 64'd0);
                  n++;
               end
            end
            frp_pkg::MODE_REST: begin
               if (b == frp_pkg::LINE_FEED) begin
                  parse_state = frp_pkg::MODE_SEQ;
                  line_start  = 1'b1;
               end
            end
            default: begin
               if (line_start && b == frp_pkg::HEADER_MARK) begin
                  res[n] = make_result(frp_pkg::KIND_END, 8'h00, letters);
                  n++;
                  letters     = 64'd0;
                  parse_state = frp_pkg::MODE_NAME;
                  line_start  = 1'b0;
               end else if (b == frp_pkg::LINE_FEED) begin
                  line_start = 1'b1;
               end else begin
                  line_start = 1'b0;
                  if (alpha_byte(b)) begin
                     if (letters < COUNT_MAX) letters++;
                     res[n] = make_result(frp_pkg::KIND_LETTER, b, 64'd0);
                     n++;
                  end
               end
            end
         endcase
      end
      if (n > 0) res[n-1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
   endtask

   // ------------------------------------------------------ monitor and checker

   // Predict before checking so a same-edge result would still find its entry.
   always @(posedge clock) begin
      frp_pkg::result_type want;
      logic                bad;
      if (!reset) begin
         if (req_tvalid && req_tready)
            predict_parse(frp_pkg::op_type'(req_tuser[0]), req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected word: kind %0d char %02h length %0d last %0b",
                           rsp_tdata[2:0], rsp_tdata[10:3], rsp_tdata[42:11], rsp_tlast);
            end else begin
               want = expected_results.pop_front();
               bad  = (rsp_tdata[2:0]   !== want.kind)          ||
                      (rsp_tdata[10:3]  !== want.char_out)      ||
                      (rsp_tdata[42:11] !== want.record_length) ||
                      (rsp_tdata[47:43] !== 5'd0)               ||
                      (rsp_tlast        !== want.last_of_run);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"mismatch (expected/actual): kind %0d/%0d char %02h/%02h",
                               " length %0d/%0d pad %0d last %0b/%0b"},
                              want.kind, rsp_tdata[2:0], want.char_out, rsp_tdata[10:3],
                              want.record_length, rsp_tdata[42:11], rsp_tdata[47:43],
                              want.last_of_run, rsp_tlast);
               end
            end
         end
      end
   end

   // Receiver: hold each stall style for a random stretch of cycles.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style = $urandom_range(STALL_NONE, STALL_LONG);
         stall_left  = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_style)
         STALL_NONE:     rsp_tready <= 1'b1;
         STALL_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         STALL_PERIODIC: rsp_tready <= (stall_left % 4 == 0);
         default:        rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_word(input frp_pkg::op_type op, input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      items_sent++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(frp_pkg::OP_BYTE, s[i]);
   endtask

   // Hold the sender off until every predicted word has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      // let the monitor log the last accepted word first
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_blank();
      logic [7:0] b;
      b = 8'($urandom_range(8'h09, 8'h0E));
      return (b == 8'h0E) ? 8'h20 : b;
   endfunction

   function automatic logic [7:0] pick_letter();
      logic [7:0] b;
      b = 8'($urandom_range(8'h41, 8'h5A));
      return $urandom_range(0, 1) ? b : (b | 8'h20);
   endfunction

   task automatic test_header_forms();
      send_word(frp_pkg::OP_EOS, 8'hA5);        // nothing open: no word
      send_word(frp_pkg::OP_BYTE, 8'h20);
      send_word(frp_pkg::OP_BYTE, 8'h09);
      send_word(frp_pkg::OP_BYTE, 8'h0A);
      send_word(frp_pkg::OP_BYTE, 8'h0B);
      send_word(frp_pkg::OP_BYTE, 8'h0C);
      send_word(frp_pkg::OP_BYTE, 8'h0D);
      send_text(">a");
      send_word(frp_pkg::OP_BYTE, 8'h09);       // name done, rest of line dropped
      send_text("x");
      send_word(frp_pkg::OP_BYTE, frp_pkg::LINE_FEED);
      send_text("Az");
      send_word(frp_pkg::OP_BYTE, frp_pkg::LINE_FEED);
      send_word(frp_pkg::OP_BYTE, frp_pkg::HEADER_MARK);  // record end, then empty name
      send_word(frp_pkg::OP_BYTE, frp_pkg::LINE_FEED);
      drain_results();
   endtask

   task automatic test_sequence_lines();
      send_text("Z@{");
      send_word(frp_pkg::OP_BYTE, 8'hFF);
      send_word(frp_pkg::OP_BYTE, 8'h80);
      send_word(frp_pkg::OP_BYTE, frp_pkg::HEADER_MARK);  // mid-line marker is dropped
      send_word(frp_pkg::OP_BYTE, 8'h00);
      send_word(frp_pkg::OP_BYTE, frp_pkg::LINE_FEED);
      send_word(frp_pkg::OP_BYTE, 8'h20);                 // blank opens the line ...
      send_word(frp_pkg::OP_BYTE, frp_pkg::HEADER_MARK);  // ... so no new record here
      send_text("q");
      send_word(frp_pkg::OP_EOS, 8'h00);
      drain_results();
   endtask

   task automatic test_stream_ends();
      send_text("m");                           // unnamed, first byte is a letter
      send_word(frp_pkg::OP_EOS, 8'hFF);
      send_text("7G");                          // unnamed, first byte not a letter
      send_word(frp_pkg::OP_EOS, 8'h00);
      send_text(">q");
      send_word(frp_pkg::OP_EOS, 8'h5A);        // name done and empty record end
      send_text(">r s");
      send_word(frp_pkg::OP_EOS, 8'h01);
      drain_results();
   endtask

   task automatic send_fasta_stream();
      int records;
      int lines;
      int span;
      logic [7:0] b;
      repeat ($urandom_range(0, 2)) send_word(frp_pkg::OP_BYTE, pick_blank());
      records = $urandom_range(1, 3);
      for (int r = 0; r < records; r++) begin
         if (r > 0 || $urandom_range(0, 4) != 0) begin
            send_word(frp_pkg::OP_BYTE, frp_pkg::HEADER_MARK);
            span = $urandom_range(0, 6);
            for (int i = 0; i < span; i++) begin
               b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(8'h80, 8'hFF))
                                               : 8'($urandom_range(8'h21, 8'h7E));
               send_word(frp_pkg::OP_BYTE, b);
            end
            case ($urandom_range(0, 9))
               0: begin
                  send_word(frp_pkg::OP_EOS, 8'($urandom_range(0, 255)));
                  return;
               end
               1, 2, 3, 4: begin
                  send_word(frp_pkg::OP_BYTE, pick_blank());
                  repeat ($urandom_range(0, 8)) begin
                     b = 8'($urandom_range(0, 255));
                     send_word(frp_pkg::OP_BYTE, (b == frp_pkg::LINE_FEED) ? 8'h2E : b);
                  end
                  send_word(frp_pkg::OP_BYTE, frp_pkg::LINE_FEED);
               end
               default: send_word(frp_pkg::OP_BYTE, frp_pkg::LINE_FEED);
            endcase
         end else begin
            b = 8'($urandom_range(0, 255));
            if (blank_byte(b) || b == frp_pkg::HEADER_MARK) b = pick_letter();
            send_word(frp_pkg::OP_BYTE, b);
         end
         lines = $urandom_range(0, 3);
         for (int l = 0; l < lines; l++) begin
            if ($urandom_range(0, 9) == 0) send_word(frp_pkg::OP_BYTE, pick_blank());
            span = $urandom_range(0, 15);
            for (int i = 0; i < span; i++) begin
               if ($urandom_range(0, 19) < 17) begin
                  send_word(frp_pkg::OP_BYTE, pick_letter());
               end else begin
                  b = 8'($urandom_range(0, 255));
                  send_word(frp_pkg::OP_BYTE,
                            (b == frp_pkg::LINE_FEED) ? frp_pkg::HEADER_MARK : b);
               end
            end
            if (l < lines - 1 || $urandom_range(0, 9) != 0)
               send_word(frp_pkg::OP_BYTE, frp_pkg::LINE_FEED);
         end
      end
      send_word(frp_pkg::OP_EOS, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 20))
         send_word(frp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) send_word(frp_pkg::OP_EOS, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_random_streams();
      int target;
      bit paused;
      target = items_sent + RANDOM_ITEMS;
      paused = 1'b0;
      while (items_sent < target) begin
         if (!paused && items_sent > target - RANDOM_ITEMS / 2) begin
            drain_results();
            paused = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) send_noise();
         else                           send_fasta_stream();
      end
      // close whatever the last noise left open
      send_word(frp_pkg::OP_EOS, 8'h00);
   endtask

   initial begin
      int waited;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_header_forms();
      test_sequence_lines();
      test_stream_ends();
      test_random_streams();
      req_tvalid <= 1'b0;
      // let the monitor log the last accepted word first
      @(posedge clock);
      waited = 0;
      while (expected_results.size() != 0 && waited < END_WAIT_MAX) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         mismatches++;
         $display("%0d expected words never arrived", expected_results.size());
      end
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
